// ----- rtl/core/sid_pkg.sv -----
// ============================================================================
// Signed integer divider package
// The flags type shared by the stages of the signed integer divider.
// ============================================================================
package sid_pkg;

   // Side information that travels with each word down the division chain.
   typedef struct packed {
      logic neg;
      logic dbz;
   } sid_flags_type;

endpackage

// ----- rtl/core/sid_if.sv -----
// ============================================================================
// Signed integer divider channels
// Valid/ready channels for operand words and result words.
// ============================================================================
interface sid_req_if #(
   parameter int WIDTH = 32
);
   logic               valid;
   logic               ready;
   logic [WIDTH-1:0]   dividend;
   logic [WIDTH-1:0]   divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface sid_rsp_if #(
   parameter int WIDTH = 32
);
   logic               valid;
   logic               ready;
   logic [WIDTH-1:0]   quotient;
   logic               overflow;
   logic               divide_by_zero;

   modport source (output valid, output quotient, output overflow,
                   output divide_by_zero, input ready);
   modport sink (input valid, input quotient, input overflow,
                 input divide_by_zero, output ready);
endinterface

// ----- rtl/core/signed_integer_divider.sv -----
// ============================================================================
// Signed integer divider
// Pipelined restoring divider, quotient truncated toward zero.
// ============================================================================
// Operand words arrive on req_bus (dividend, divisor) and result words leave
// on rsp_bus (quotient, overflow, divide_by_zero), both valid/ready channels.
// One result word is produced for every operand word, in order.
// A word passes through one operand stage that takes magnitudes, WIDTH
// division cells that each settle one quotient bit, and an output register
// that applies the sign. Throughput is one word per cycle unless stalled.
// Every stage holds its own valid bit and takes a new word whenever it is
// empty or its neighbor takes its word, so bubbles close up and the divider
// keeps accepting while the output register holds an untaken result; a long
// stall fills the chain, then req_bus.ready falls.
// A zero divisor gives quotient 0 with divide_by_zero set. The minimum value
// divided by minus one gives the maximum value with overflow set.
// Reset empties every stage; no result is pending afterward.
// ============================================================================
module signed_integer_divider #(
   parameter int WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   sid_req_if.sink    req_bus,
   sid_rsp_if.source  rsp_bus
);

   localparam logic [WIDTH-1:0] MaxPos = {1'b0, {(WIDTH-1){1'b1}}};

   logic                   valid_s [0:WIDTH];
   logic                   ready_s [0:WIDTH];
   sid_pkg::sid_flags_type flags_s [0:WIDTH];
   logic [WIDTH-1:0]       mag_s   [0:WIDTH];
   logic [WIDTH-1:0]       rem_s   [0:WIDTH];
   logic [WIDTH-1:0]       work_s  [0:WIDTH];

   assign rem_s[0] = '0;

   sid_prep #(.WIDTH(WIDTH)) u_prep (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_bus.valid),
      .in_ready        (req_bus.ready),
      .in_dividend     (req_bus.dividend),
      .in_divisor      (req_bus.divisor),
      .out_valid       (valid_s[0]),
      .out_ready       (ready_s[0]),
      .out_flags       (flags_s[0]),
      .out_mag_divisor (mag_s[0]),
      .out_work        (work_s[0])
   );

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      sid_cell #(.WIDTH(WIDTH)) u_cell (
         .clock           (clock),
         .reset           (reset),
         .in_valid        (valid_s[i]),
         .in_ready        (ready_s[i]),
         .in_flags        (flags_s[i]),
         .in_mag_divisor  (mag_s[i]),
         .in_rem          (rem_s[i]),
         .in_work         (work_s[i]),
         .out_valid       (valid_s[i+1]),
         .out_ready       (ready_s[i+1]),
         .out_flags       (flags_s[i+1]),
         .out_mag_divisor (mag_s[i+1]),
         .out_rem         (rem_s[i+1]),
         .out_work        (work_s[i+1])
      );
   end

   sid_post #(.WIDTH(WIDTH)) u_post (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (valid_s[WIDTH]),
      .in_ready           (ready_s[WIDTH]),
      .in_flags           (flags_s[WIDTH]),
      .in_quotient        (work_s[WIDTH]),
      .out_valid          (rsp_bus.valid),
      .out_ready          (rsp_bus.ready),
      .out_quotient       (rsp_bus.quotient),
      .out_overflow       (rsp_bus.overflow),
      .out_divide_by_zero (rsp_bus.divide_by_zero)
   );

   // A word that holds an error flag carries the fixed quotient for it.
   a_dbz_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.divide_by_zero |-> rsp_bus.quotient == '0)
      else $error("Zero divisor result has a nonzero quotient.");

   a_ovf_max : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.overflow |-> rsp_bus.quotient == MaxPos)
      else $error("Overflow result is not the saturated maximum.");

   a_flags_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.overflow && rsp_bus.divide_by_zero))
      else $error("Overflow and zero divisor flagged together.");

   // The remainder leaving the last cell stays below a nonzero divisor magnitude.
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      valid_s[WIDTH] && !flags_s[WIDTH].dbz |-> rem_s[WIDTH] < mag_s[WIDTH])
      else $error("Final remainder is not below the divisor.");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("Result pending right after reset.");

endmodule

// ----- rtl/core/sid_prep.sv -----
// ============================================================================
// Signed integer divider operand stage
// Registers operand magnitudes, the quotient sign and the zero divisor flag.
// ============================================================================
module sid_prep #(
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [WIDTH-1:0]      in_dividend,
   input  logic [WIDTH-1:0]      in_divisor,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sid_pkg::sid_flags_type out_flags,
   output logic [WIDTH-1:0]      out_mag_divisor,
   output logic [WIDTH-1:0]      out_work
);

   logic                  valid_ff;
   sid_pkg::sid_flags_type flags_ff, flags_in;
   logic [WIDTH-1:0]      mag_divisor_ff, mag_divisor_in;
   logic [WIDTH-1:0]      work_ff, work_in;
   logic                  neg_a, neg_b;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      neg_a          = in_dividend[WIDTH-1];
      neg_b          = in_divisor[WIDTH-1];
      work_in        = neg_a ? (~in_dividend + 1'b1) : in_dividend;
      mag_divisor_in = neg_b ? (~in_divisor + 1'b1) : in_divisor;
      flags_in.neg   = neg_a ^ neg_b;
      flags_in.dbz   = (in_divisor == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         flags_ff       <= flags_in;
         mag_divisor_ff <= mag_divisor_in;
         work_ff        <= work_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_flags       = flags_ff;
   assign out_mag_divisor = mag_divisor_ff;
   assign out_work        = work_ff;

endmodule

// ----- rtl/core/sid_cell.sv -----
// ============================================================================
// Signed integer divider cell
// One restoring shift-and-subtract step on the magnitudes, with its register.
// ============================================================================
module sid_cell #(
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sid_pkg::sid_flags_type in_flags,
   input  logic [WIDTH-1:0]      in_mag_divisor,
   input  logic [WIDTH-1:0]      in_rem,
   input  logic [WIDTH-1:0]      in_work,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sid_pkg::sid_flags_type out_flags,
   output logic [WIDTH-1:0]      out_mag_divisor,
   output logic [WIDTH-1:0]      out_rem,
   output logic [WIDTH-1:0]      out_work
);

   logic                  valid_ff;
   sid_pkg::sid_flags_type flags_ff;
   logic [WIDTH-1:0]      mag_divisor_ff;
   logic [WIDTH-1:0]      rem_ff, rem_in;
   logic [WIDTH-1:0]      work_ff, work_in;
   logic [WIDTH-1:0]      trial;
   logic                  fits;

   assign in_ready = !valid_ff || out_ready;

   // For a nonzero divisor the remainder stays below its magnitude, so its top
   // bit is zero and the shifted value still fits in WIDTH bits.
   always_comb begin
      trial   = {in_rem[WIDTH-2:0], in_work[WIDTH-1]};
      fits    = (trial >= in_mag_divisor);
      rem_in  = fits ? (trial - in_mag_divisor) : trial;
      work_in = {in_work[WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         flags_ff       <= in_flags;
         mag_divisor_ff <= in_mag_divisor;
         rem_ff         <= rem_in;
         work_ff        <= work_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_flags       = flags_ff;
   assign out_mag_divisor = mag_divisor_ff;
   assign out_rem         = rem_ff;
   assign out_work        = work_ff;

endmodule

// ----- rtl/core/sid_post.sv -----
// ============================================================================
// Signed integer divider result stage
// Applies the sign, saturation and zero divisor rules into the output register.
// ============================================================================
module sid_post #(
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sid_pkg::sid_flags_type in_flags,
   input  logic [WIDTH-1:0]      in_quotient,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [WIDTH-1:0]      out_quotient,
   output logic                  out_overflow,
   output logic                  out_divide_by_zero
);

   localparam logic [WIDTH-1:0] MaxPos = {1'b0, {(WIDTH-1){1'b1}}};

   logic             valid_ff;
   logic [WIDTH-1:0] quotient_ff, quotient_in;
   logic             overflow_ff, overflow_in;
   logic             dbz_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      overflow_in = 1'b0;
      if (in_flags.dbz) begin
         quotient_in = '0;
      end else if (in_flags.neg) begin
         quotient_in = ~in_quotient + 1'b1;
      end else if (in_quotient[WIDTH-1]) begin
         quotient_in = MaxPos;
         overflow_in = 1'b1;
      end else begin
         quotient_in = in_quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         quotient_ff <= quotient_in;
         overflow_ff <= overflow_in;
         dbz_ff      <= in_flags.dbz;
      end
   end

   assign out_valid          = valid_ff;
   assign out_quotient       = quotient_ff;
   assign out_overflow       = overflow_ff;
   assign out_divide_by_zero = dbz_ff;

endmodule
